// ----- sv/rfdf_pkg.sv -----
package rfdf_pkg;

	localparam int MAX_SAMPLES = 32;
	localparam int FRAME_BYTES = 7;
	localparam int Q_DEPTH = 2;

	localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int WIN_IDX_W = $clog2(FRAME_BYTES);
	localparam int FILL_W = $clog2(FRAME_BYTES + 1);

	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [15:0] IDLE_MAX = 16'hFFFF;

	localparam logic [1:0] ST_GOOD = 2'd0;
	localparam logic [1:0] ST_OOR = 2'd1;
	localparam logic [1:0] ST_OFF = 2'd2;

	localparam logic [1:0] MODE_AVG = 2'd0;
	localparam logic [1:0] MODE_MEDIAN = 2'd1;
	localparam logic [1:0] MODE_DUAL = 2'd2;
	localparam logic [1:0] MODE_NONE = 2'd3;

	localparam logic [2:0] REG_FILTER_MODE = 3'd0;
	localparam logic [2:0] REG_SAMPLE_WINDOW = 3'd1;
	localparam logic [2:0] REG_RANGE_BIAS = 3'd2;
	localparam logic [2:0] REG_ALT_MIN = 3'd3;
	localparam logic [2:0] REG_ALT_MAX = 3'd4;
	localparam logic [2:0] REG_TIMEOUT = 3'd5;
	localparam logic [2:0] REG_FORCE_GOOD = 3'd6;
	localparam logic [2:0] REG_CRC_POLY = 3'd7;

	typedef struct packed {
		logic [1:0] filter_mode;
		logic [5:0] sample_window;
		logic signed [15:0] range_bias;
		logic signed [17:0] alt_min_mm;
		logic signed [17:0] alt_max_mm;
		logic [15:0] timeout_ticks;
		logic force_good;
		logic [7:0] crc_poly;
	} cfg_t;

	typedef struct packed {
		logic action;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic signed [17:0] altitude_mm;
		logic [1:0] status;
		logic fresh_value;
	} result_t;

	typedef struct packed {
		logic off;
		logic signed [17:0] range;
	} job_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CHECK,
		F_CRC
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_DIV,
		B_MRDI,
		B_MCAPI,
		B_MRDJ,
		B_MCMP,
		B_STAT
	} back_state_t;

endpackage

// ----- sv/rfdf_queue.sv -----
module rfdf_queue
	import rfdf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic wr,
	input job_t wr_data,
	output logic q_full,
	input logic rd,
	output job_t rd_data,
	output logic q_empty
);

	localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QC_W = $clog2(Q_DEPTH + 1);

	job_t mem_q [Q_DEPTH];
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [QC_W-1:0] count_q;

	assign q_full = (count_q == QC_W'(Q_DEPTH));
	assign q_empty = (count_q == '0);
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= (rp_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

endmodule

// ----- sv/rfdf_front.sv -----
module rfdf_front
	import rfdf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic push,
	input item_t item,
	output logic full,
	input logic q_full,
	output logic enq,
	output job_t enq_job
);

	front_state_t state_q;
	front_state_t state_d;
	logic [7:0] win_q [FRAME_BYTES];
	logic [FILL_W-1:0] fill_q;
	logic [15:0] idle_q;
	logic off_q;
	logic [7:0] crc_q;
	logic [2:0] cidx_q;

	logic accept;
	logic [15:0] idle_inc;
	logic tick_fire;
	logic [3:0] len;
	logic [3:0] base;
	logic frame_ok;
	logic [7:0] crc_byte;
	logic [7:0] crc_next;
	logic crc_last;
	logic crc_match;
	logic frame_done;
	logic [15:0] raw_range;

	assign accept = push && !full;
	assign idle_inc = (idle_q == IDLE_MAX) ? idle_q : idle_q + 1'b1;
	assign tick_fire = (idle_inc > cfg.timeout_ticks) && !off_q;

	always_comb begin
		len = (cfg.filter_mode == MODE_DUAL) ? 4'd7 : 4'd4;
		base = 4'(FRAME_BYTES) - len;
		frame_ok = 1'b1;
		if (cfg.filter_mode == MODE_NONE) begin
			frame_ok = 1'b0;
		end
		if (len > 4'(FRAME_BYTES)) begin
			frame_ok = 1'b0;
		end else begin
			if (fill_q < FILL_W'(len)) begin
				frame_ok = 1'b0;
			end
			if (win_q[WIN_IDX_W'(base)] != CH_T) begin
				frame_ok = 1'b0;
			end
			if (len == 4'd7 && win_q[WIN_IDX_W'(base + 4'd3)] != CH_S) begin
				frame_ok = 1'b0;
			end
		end
	end

	always_comb begin
		logic [7:0] c;
		c = crc_q ^ crc_byte;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ cfg.crc_poly) : {c[6:0], 1'b0};
		end
		crc_next = c;
	end

	assign crc_byte = win_q[WIN_IDX_W'(base + 4'(cidx_q))];
	assign crc_last = (4'(cidx_q) == len - 4'd2);
	assign crc_match = (crc_next == win_q[FRAME_BYTES-1]);
	assign raw_range = {win_q[WIN_IDX_W'(base + 4'd1)], win_q[WIN_IDX_W'(base + 4'd2)]};
	assign frame_done = (state_q == F_CRC) && crc_last && crc_match && !q_full;

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (accept && !item.action) begin
					state_d = F_CHECK;
				end
			end
			F_CHECK: begin
				state_d = frame_ok ? F_CRC : F_IDLE;
			end
			F_CRC: begin
				if (crc_last && (!crc_match || !q_full)) begin
					state_d = F_IDLE;
				end
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

	always_comb begin
		full = (state_q != F_IDLE) || q_full;
		enq = 1'b0;
		enq_job.off = 1'b0;
		enq_job.range = 18'($signed({2'b00, raw_range})) + 18'(cfg.range_bias);
		case (state_q)
			F_IDLE: begin
				if (accept && item.action && tick_fire) begin
					enq = 1'b1;
					enq_job.off = 1'b1;
				end
			end
			F_CRC: begin
				enq = frame_done;
			end
			default: begin
				enq = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			fill_q <= '0;
			idle_q <= '0;
			off_q <= 1'b1;
			for (int i = 0; i < FRAME_BYTES; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (accept && item.action) begin
				idle_q <= idle_inc;
				if (tick_fire) begin
					off_q <= 1'b1;
				end
			end
			if (accept && !item.action) begin
				for (int i = 0; i < FRAME_BYTES - 1; i++) begin
					win_q[i] <= win_q[i+1];
				end
				win_q[FRAME_BYTES-1] <= item.rx_byte;
				if (fill_q != FILL_W'(FRAME_BYTES)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (frame_done) begin
				fill_q <= '0;
				idle_q <= '0;
				off_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_CHECK) begin
			crc_q <= '0;
			cidx_q <= '0;
		end else if (state_q == F_CRC && !crc_last) begin
			crc_q <= crc_next;
			cidx_q <= cidx_q + 1'b1;
		end
	end

endmodule

// ----- sv/rfdf_back.sv -----
module rfdf_back
	import rfdf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic q_empty,
	input job_t q_job,
	output logic q_pop,
	output logic empty,
	input logic pop,
	output result_t result
);

	back_state_t state_q;
	back_state_t state_d;
	logic signed [17:0] store_q [MAX_SAMPLES];
	logic signed [17:0] rd_q;
	logic signed [17:0] alt_q;
	logic signed [23:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic fresh_q;
	logic out_valid_q;
	result_t out_q;
	logic [23:0] dq_q;
	logic [5:0] rem_q;
	logic [5:0] div_q;
	logic neg_q;
	logic [4:0] dcnt_q;
	logic [IDX_W-1:0] mi_q;
	logic [IDX_W-1:0] mj_q;
	logic [CNT_W-1:0] rank_q;
	logic signed [17:0] vi_q;

	logic [CNT_W-1:0] n_eff;
	logic [CNT_W-1:0] cnt_inc;
	logic signed [23:0] sum_inc;
	logic [6:0] rem_sh;
	logic div_bit;
	logic [5:0] rem_nx;
	logic [23:0] quo;
	logic div_last;
	logic less;
	logic [CNT_W-1:0] rank_nx;
	logic scan_last;
	logic [IDX_W-1:0] rd_addr;
	logic [1:0] status_nx;
	logic load_stat;
	logic load_off;

	always_comb begin
		if (cfg.sample_window == '0) begin
			n_eff = CNT_W'(1);
		end else if ({1'b0, cfg.sample_window} > 7'(MAX_SAMPLES)) begin
			n_eff = CNT_W'(MAX_SAMPLES);
		end else begin
			n_eff = CNT_W'(cfg.sample_window);
		end
	end

	assign cnt_inc = cnt_q + 1'b1;
	assign sum_inc = sum_q + 24'(q_job.range);

	assign rem_sh = {rem_q, dq_q[23]};
	assign div_bit = (rem_sh >= {1'b0, div_q});
	assign rem_nx = div_bit ? 6'(rem_sh - {1'b0, div_q}) : rem_sh[5:0];
	assign quo = {dq_q[22:0], div_bit};
	assign div_last = (dcnt_q == 5'd23);

	assign less = (rd_q < vi_q) || ((rd_q == vi_q) && (mj_q < mi_q));
	assign rank_nx = rank_q + CNT_W'(less);
	assign scan_last = (CNT_W'(mj_q) == n_eff - 1'b1);
	assign rd_addr = (state_q == B_MRDI) ? mi_q : mj_q;

	assign status_nx = (cfg.force_good || (alt_q > cfg.alt_min_mm && alt_q < cfg.alt_max_mm))
		? ST_GOOD : ST_OOR;

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (q_pop && !q_job.off) begin
					if (cnt_inc >= n_eff) begin
						state_d = (cfg.filter_mode == MODE_MEDIAN) ? B_MRDI : B_DIV;
					end else begin
						state_d = B_STAT;
					end
				end
			end
			B_DIV: begin
				if (div_last) begin
					state_d = B_STAT;
				end
			end
			B_MRDI: begin
				state_d = B_MCAPI;
			end
			B_MCAPI: begin
				state_d = B_MRDJ;
			end
			B_MRDJ: begin
				state_d = B_MCMP;
			end
			B_MCMP: begin
				if (!scan_last) begin
					state_d = B_MRDJ;
				end else if (rank_nx == (n_eff >> 1)) begin
					state_d = B_STAT;
				end else begin
					state_d = B_MRDI;
				end
			end
			B_STAT: begin
				state_d = B_IDLE;
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		load_off = 1'b0;
		load_stat = 1'b0;
		case (state_q)
			B_IDLE: begin
				q_pop = !q_empty && !out_valid_q;
				load_off = q_pop && q_job.off;
			end
			B_STAT: begin
				load_stat = 1'b1;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	assign empty = !out_valid_q;
	assign result = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_valid_q <= 1'b0;
			alt_q <= '0;
			sum_q <= '0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (load_off || load_stat) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop && !q_job.off) begin
				if (cfg.filter_mode == MODE_MEDIAN) begin
					cnt_q <= (cnt_inc >= n_eff) ? '0 : cnt_inc;
				end else begin
					sum_q <= (cnt_inc >= n_eff) ? '0 : sum_inc;
					cnt_q <= (cnt_inc >= n_eff) ? '0 : cnt_inc;
				end
			end
			if (state_q == B_DIV && div_last) begin
				alt_q <= neg_q ? 18'(-quo) : 18'(quo);
			end
			if (state_q == B_MCMP && scan_last && rank_nx == (n_eff >> 1)) begin
				alt_q <= vi_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= store_q[rd_addr];
		if (q_pop && !q_job.off && cfg.filter_mode == MODE_MEDIAN
			&& cnt_q < CNT_W'(MAX_SAMPLES)) begin
			store_q[cnt_q[IDX_W-1:0]] <= q_job.range;
		end
		if (q_pop && !q_job.off) begin
			fresh_q <= (cnt_inc >= n_eff);
			neg_q <= sum_inc[23];
			dq_q <= sum_inc[23] ? 24'(-sum_inc) : 24'(sum_inc);
			rem_q <= '0;
			div_q <= 6'(cnt_inc);
			dcnt_q <= '0;
			mi_q <= '0;
			mj_q <= '0;
			rank_q <= '0;
		end
		if (state_q == B_DIV) begin
			dq_q <= quo;
			rem_q <= rem_nx;
			dcnt_q <= dcnt_q + 1'b1;
		end
		if (state_q == B_MCAPI) begin
			vi_q <= rd_q;
		end
		if (state_q == B_MCMP) begin
			if (scan_last) begin
				mi_q <= mi_q + 1'b1;
				mj_q <= '0;
				rank_q <= '0;
			end else begin
				mj_q <= mj_q + 1'b1;
				rank_q <= rank_nx;
			end
		end
		if (load_off) begin
			out_q.altitude_mm <= alt_q;
			out_q.status <= ST_OFF;
			out_q.fresh_value <= 1'b0;
		end
		if (load_stat) begin
			out_q.altitude_mm <= alt_q;
			out_q.status <= status_nx;
			out_q.fresh_value <= fresh_q;
		end
	end

endmodule

// ----- sv/range_frame_decode_filter.sv -----
// Decodes rangefinder frames from a byte and tick stream and filters the ranges.
// A tick is taken while the front end is idle. A byte is shifted in, its frame
// markers are then tested and, when they match, the byte-serial CRC unit in the
// front end steps over the bytes that the CRC covers (three for a single frame,
// six for a dual frame). A valid frame is queued to the back end, which gives a
// status-only result when no filtered value is due, runs a 24-step divider for an
// averaged value and, for a median of n samples, a rank selection that scans the
// sample memory through its single read port.
module range_frame_decode_filter
	import rfdf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input item_t item,
	output logic empty,
	input logic pop,
	output result_t result,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [17:0] cfg_data
);

	cfg_t cfg_q;
	logic enq;
	job_t enq_job;
	logic q_full;
	logic q_empty;
	logic q_pop;
	job_t q_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_mode <= MODE_AVG;
			cfg_q.sample_window <= 6'd1;
			cfg_q.range_bias <= '0;
			cfg_q.alt_min_mm <= '0;
			cfg_q.alt_max_mm <= 18'sd65535;
			cfg_q.timeout_ticks <= 16'd100;
			cfg_q.force_good <= 1'b0;
			cfg_q.crc_poly <= 8'h07;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FILTER_MODE: cfg_q.filter_mode <= cfg_data[1:0];
				REG_SAMPLE_WINDOW: cfg_q.sample_window <= cfg_data[5:0];
				REG_RANGE_BIAS: cfg_q.range_bias <= cfg_data[15:0];
				REG_ALT_MIN: cfg_q.alt_min_mm <= cfg_data;
				REG_ALT_MAX: cfg_q.alt_max_mm <= cfg_data;
				REG_TIMEOUT: cfg_q.timeout_ticks <= cfg_data[15:0];
				REG_FORCE_GOOD: cfg_q.force_good <= cfg_data[0];
				REG_CRC_POLY: cfg_q.crc_poly <= cfg_data[7:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	rfdf_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.push(push),
		.item(item),
		.full(full),
		.q_full(q_full),
		.enq(enq),
		.enq_job(enq_job)
	);

	rfdf_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr(enq),
		.wr_data(enq_job),
		.q_full(q_full),
		.rd(q_pop),
		.rd_data(q_job),
		.q_empty(q_empty)
	);

	rfdf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_empty(q_empty),
		.q_job(q_job),
		.q_pop(q_pop),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

`ifndef ASSERT_OFF
	a_fresh_not_off: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.fresh_value) |-> (result.status != ST_OFF))
		else $error("A fresh result carries status off.");

	a_byte_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && !item.action) |=> full)
		else $error("Front end took a byte without testing it.");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("Waiting result changed before its transfer.");
`endif

endmodule
